### sv/bvre_pkg.sv
// ============================================================================
// Bit vector range engine package
// Shared types and constants for the bitmap range engine and its word unit.
// ============================================================================
`default_nettype none

package bvre_pkg;

   // Width of one bitmap word and of the bit offset inside it.
   localparam int WORD_BITS   = 32;
   localparam int OFFSET_BITS = 5;

   // Field widths of the request, response and register beats.
   localparam int KIND_BITS = 3;
   localparam int POS_BITS  = 8;
   localparam int BIU_BITS  = 9;

   // Value of the vector length register after reset.
   localparam logic [BIU_BITS-1:0] BIU_RESET = 9'd256;

   // Operation codes carried in the kind field of a request beat.
   typedef enum logic [KIND_BITS-1:0] {
      KIND_SET_BIT     = 3'd0,
      KIND_CLEAR_BIT   = 3'd1,
      KIND_SET_RANGE   = 3'd2,
      KIND_CLEAR_RANGE = 3'd3,
      KIND_TEST_RANGE  = 3'd4,
      KIND_SET_ALL     = 3'd5,
      KIND_CLEAR_ALL   = 3'd6,
      KIND_FIND_HIGH   = 3'd7
   } kind_type;

   // Operation that the word unit applies to each visited word.
   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_TEST  = 2'd2,
      OP_FIND  = 2'd3
   } op_type;

   // Result of the word unit for one visited word.
   typedef struct packed {
      logic [WORD_BITS-1:0]   new_word;
      logic                   any_hit;
      logic                   nonzero;
      logic [OFFSET_BITS-1:0] msb;
   } word_result_type;

endpackage

`default_nettype wire

### sv/bvre_req_if.sv
// ============================================================================
// Request channel
// Valid/ready channel that carries one operation beat into the engine.
// ============================================================================
`default_nettype none

interface bvre_req_if import bvre_pkg::*; ();

   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [POS_BITS-1:0]  start_req;
   logic [POS_BITS-1:0]  end_pos;

   modport source (output valid, output kind, output start_req, output end_pos,
                   input ready);
   modport sink   (input valid, input kind, input start_req, input end_pos,
                   output ready);

endinterface

`default_nettype wire

### sv/bvre_rsp_if.sv
// ============================================================================
// Response channel
// Valid/ready channel that carries one result beat out of the engine.
// ============================================================================
`default_nettype none

interface bvre_rsp_if import bvre_pkg::*; ();

   logic                valid;
   logic                ready;
   logic                hit;
   logic [POS_BITS-1:0] position;
   logic                error;

   modport source (output valid, output hit, output position, output error,
                   input ready);
   modport sink   (input valid, input hit, input position, input error,
                   output ready);

endinterface

`default_nettype wire

### sv/bit_vector_range_engine.sv
// ============================================================================
// Bit vector range engine
// Bitmap of WORDS 32-bit words with bit and range set, clear and test, set
// and clear of all covered words, and a search for the highest set bit.
// ============================================================================
// Operation: one item at a time. The engine reads the words that an item
//   covers one word per cycle through the single read port and the shared
//   word unit, then posts the result beat from the done state; an item that
//   visits no word goes straight to the done state. The next request is
//   taken once the engine is back in idle. An untaken result beat stalls
//   the done state. Reset: synchronous; the bitmap reads as all zero through
//   per-word valid bits and the vector length register returns to 256.
// ============================================================================
`default_nettype none

module bit_vector_range_engine import bvre_pkg::*; #(
   parameter int WORDS = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   bvre_req_if.sink                 req_bus,
   bvre_rsp_if.source               rsp_bus,
   input  wire logic                csr_write_en,
   input  wire logic [BIU_BITS-1:0] csr_write_data
);

   localparam int WI = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SW = 7;
   localparam logic [SW-1:0] WORDS_W = SW'(WORDS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // Control and result registers.
   state_type              state_ff, state_in;
   logic [BIU_BITS-1:0]    biu_ff;
   op_type                 op_ff, op_in;
   logic [POS_BITS-1:0]    s_ff, s_in;
   logic [POS_BITS-1:0]    e_ff, e_in;
   logic                   bound_lo_ff, bound_lo_in;
   logic                   bound_hi_ff, bound_hi_in;
   logic                   down_ff, down_in;
   logic [WI-1:0]          cur_ff, cur_in;
   logic [WI-1:0]          last_ff, last_in;
   logic                   first_ff, first_in;
   logic                   issue_ff, issue_in;
   logic                   pend_ff, pend_in;
   logic [WI-1:0]          pend_w_ff, pend_w_in;
   logic                   pend_first_ff, pend_first_in;
   logic                   pend_last_ff, pend_last_in;
   logic                   hit_acc_ff, hit_acc_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic                   err_ff, err_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_hit_ff, rsp_hit_in;
   logic [POS_BITS-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                   rsp_err_ff, rsp_err_in;
   logic [WORDS-1:0]       valid_ff;

   // Memory and its registered read port.
   logic [WORD_BITS-1:0]   bitmap_mem [WORDS];
   logic [WORD_BITS-1:0]   rd_data_ff;
   logic                   rd_valid_ff;
   logic                   wr_en;

   // Request decode helpers.
   kind_type               req_kind;
   logic [SW-1:0]          s_word;
   logic [SW-1:0]          e_word;
   logic [9:0]             cov_sum;
   logic [SW-1:0]          cov_raw;
   logic [SW-1:0]          cov_words;
   logic [SW-1:0]          lo_word;
   logic [SW-1:0]          hi_word;
   logic                   no_words;
   logic                   dec_err;

   // Word unit connections.
   logic [WORD_BITS-1:0]   word_cur;
   logic [OFFSET_BITS-1:0] lo_bit;
   logic [OFFSET_BITS-1:0] hi_bit;
   word_result_type        wres;
   logic [POS_BITS-1:0]    pend_base;
   logic                   finish;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.hit      = rsp_hit_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.error    = rsp_err_ff;

   // A word never written reads as zero.
   assign word_cur  = rd_valid_ff ? rd_data_ff : '0;
   assign lo_bit    = (pend_first_ff && bound_lo_ff) ? s_ff[4:0] : 5'd0;
   assign hi_bit    = (pend_last_ff && bound_hi_ff) ? e_ff[4:0] : 5'd31;
   assign pend_base = POS_BITS'({pend_w_ff, 5'b0});

   bvre_word_unit u_word (
      .op      (op_ff),
      .lo_bit  (lo_bit),
      .hi_bit  (hi_bit),
      .word_in (word_cur),
      .result  (wres)
   );

   // Word span of the incoming request.
   assign req_kind  = kind_type'(req_bus.kind);
   assign s_word    = SW'(req_bus.start_req[7:5]);
   assign e_word    = SW'(req_bus.end_pos[7:5]);
   assign cov_sum   = 10'(biu_ff) + 10'd31;
   assign cov_raw   = SW'(cov_sum[9:5]);
   assign cov_words = (cov_raw > WORDS_W) ? WORDS_W : cov_raw;

   always_comb begin
      lo_word  = s_word;
      hi_word  = s_word;
      no_words = 1'b0;
      dec_err  = 1'b0;
      unique case (req_kind)
         KIND_SET_BIT, KIND_CLEAR_BIT: begin
            no_words = (s_word >= WORDS_W);
         end
         KIND_SET_RANGE, KIND_CLEAR_RANGE, KIND_TEST_RANGE: begin
            dec_err  = (req_bus.start_req > req_bus.end_pos);
            hi_word  = (e_word >= WORDS_W) ? (WORDS_W - 7'd1) : e_word;
            no_words = dec_err || (s_word >= WORDS_W);
         end
         KIND_SET_ALL, KIND_CLEAR_ALL: begin
            lo_word  = '0;
            hi_word  = cov_words - 7'd1;
            no_words = (cov_words == '0);
         end
         KIND_FIND_HIGH: begin
            lo_word  = cov_words - 7'd1;
            hi_word  = '0;
            no_words = (cov_words == '0);
         end
         default: begin
            no_words = 1'b1;
         end
      endcase
   end

   // Sequencer: accept, walk the words one per cycle, then post the result.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      bound_lo_in   = bound_lo_ff;
      bound_hi_in   = bound_hi_ff;
      down_in       = down_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      first_in      = first_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pend_w_in     = pend_w_ff;
      pend_first_in = pend_first_ff;
      pend_last_in  = pend_last_ff;
      hit_acc_in    = hit_acc_ff;
      pos_in        = pos_ff;
      err_in        = err_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_err_in    = rsp_err_ff;
      wr_en         = 1'b0;
      finish        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               unique case (req_kind)
                  KIND_SET_BIT, KIND_SET_RANGE, KIND_SET_ALL: op_in = OP_SET;
                  KIND_CLEAR_BIT, KIND_CLEAR_RANGE, KIND_CLEAR_ALL: op_in = OP_CLEAR;
                  KIND_TEST_RANGE: op_in = OP_TEST;
                  default: op_in = OP_FIND;
               endcase
               s_in = req_bus.start_req;
               if (req_kind == KIND_SET_BIT || req_kind == KIND_CLEAR_BIT) begin
                  e_in = req_bus.start_req;
               end else begin
                  e_in = req_bus.end_pos;
               end
               bound_lo_in = (req_kind == KIND_SET_BIT) || (req_kind == KIND_CLEAR_BIT)
                          || (req_kind == KIND_SET_RANGE)
                          || (req_kind == KIND_CLEAR_RANGE)
                          || (req_kind == KIND_TEST_RANGE);
               // A single bit always ends in its own word; a range ends in the
               // last word only when its end lies inside the bitmap.
               bound_hi_in = (req_kind == KIND_SET_BIT) || (req_kind == KIND_CLEAR_BIT)
                          || (bound_lo_in && (e_word < WORDS_W));
               down_in     = (req_kind == KIND_FIND_HIGH);
               cur_in      = lo_word[WI-1:0];
               last_in     = hi_word[WI-1:0];
               first_in    = 1'b1;
               issue_in    = !no_words;
               pend_in     = 1'b0;
               hit_acc_in  = 1'b0;
               pos_in      = '0;
               err_in      = dec_err;
               state_in    = no_words ? ST_DONE : ST_RUN;
            end
         end
         ST_RUN: begin
            // Process the word whose read data has just arrived.
            if (pend_ff) begin
               if (op_ff == OP_SET || op_ff == OP_CLEAR) begin
                  wr_en = 1'b1;
               end
               if (op_ff == OP_TEST && wres.any_hit) begin
                  hit_acc_in = 1'b1;
               end
               if (op_ff == OP_FIND && wres.nonzero) begin
                  hit_acc_in = 1'b1;
                  pos_in     = pend_base | POS_BITS'(wres.msb);
                  finish     = 1'b1;
               end
               if (pend_last_ff) begin
                  finish = 1'b1;
               end
            end
            // Issue the read of the next word unless the walk is over.
            if (finish) begin
               issue_in = 1'b0;
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else if (issue_ff) begin
               pend_in       = 1'b1;
               pend_w_in     = cur_ff;
               pend_first_in = first_ff;
               pend_last_in  = (cur_ff == last_ff);
               first_in      = 1'b0;
               if (cur_ff == last_ff) begin
                  issue_in = 1'b0;
               end else if (down_ff) begin
                  cur_in = cur_ff - WI'(1);
               end else begin
                  cur_in = cur_ff + WI'(1);
               end
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_acc_ff;
               rsp_pos_in   = pos_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, registered outputs and per-word valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         biu_ff       <= BIU_RESET;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            biu_ff <= csr_write_data;
         end
         if (wr_en) begin
            valid_ff[pend_w_ff] <= 1'b1;
         end
      end
      op_ff         <= op_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      bound_lo_ff   <= bound_lo_in;
      bound_hi_ff   <= bound_hi_in;
      down_ff       <= down_in;
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      first_ff      <= first_in;
      pend_w_ff     <= pend_w_in;
      pend_first_ff <= pend_first_in;
      pend_last_ff  <= pend_last_in;
      hit_acc_ff    <= hit_acc_in;
      pos_ff        <= pos_in;
      err_ff        <= err_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_err_ff    <= rsp_err_in;
   end

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[pend_w_ff] <= wres.new_word;
      end
      rd_data_ff  <= bitmap_mem[cur_ff];
      rd_valid_ff <= valid_ff[cur_ff];
   end

   // Memory writes happen only while walking words.
   a_write_in_run: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_RUN))
      else $error("bitmap write outside of the word walk");

   // A result beat appears only after the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result beat raised outside of the done state");

   // A reversed range reports no hit and no position.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (!rsp_hit_ff && rsp_pos_ff == '0))
      else $error("error result carries a hit or a position");

   // A pending read exists only while walking words.
   a_pend_in_run: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_RUN))
      else $error("read in flight outside of the word walk");

   // A nonzero position only comes with a hit.
   a_pos_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pos_ff != '0) |-> rsp_hit_ff)
      else $error("position reported without a hit");

endmodule

`default_nettype wire

### sv/bvre_word_unit.sv
// ============================================================================
// Word unit
// Shared unit that masks, updates, tests and scans one 32-bit bitmap word.
// ============================================================================
`default_nettype none

module bvre_word_unit import bvre_pkg::*; (
   input  wire op_type                 op,
   input  wire logic [OFFSET_BITS-1:0] lo_bit,
   input  wire logic [OFFSET_BITS-1:0] hi_bit,
   input  wire logic [WORD_BITS-1:0]   word_in,
   output word_result_type             result
);

   logic [WORD_BITS-1:0]   mask;
   logic [OFFSET_BITS-1:0] msb;

   // Bits lo_bit through hi_bit of the word, inclusive.
   assign mask = ({WORD_BITS{1'b1}} << lo_bit)
               & ({WORD_BITS{1'b1}} >> (5'd31 - hi_bit));

   // Index of the highest set bit; the last set bit seen wins.
   always_comb begin
      msb = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (word_in[i]) begin
            msb = OFFSET_BITS'(i);
         end
      end
   end

   // Update of the word for set and clear, other operations keep it.
   always_comb begin
      result.new_word = word_in;
      case (op)
         OP_SET:   result.new_word = word_in | mask;
         OP_CLEAR: result.new_word = word_in & ~mask;
         default:  result.new_word = word_in;
      endcase
      result.any_hit = |(word_in & mask);
      result.nonzero = |word_in;
      result.msb     = msb;
   end

endmodule

`default_nettype wire

### tb/sv/bit_vector_range_engine_test.sv
// ============================================================================
// Bit vector range engine testbench
// Drives operation beats into the engine with bursty traffic, stalls the
// result channel on a shifting or random pattern, and checks every result beat against
// a shadow copy of the bitmap kept in the testbench. The vector length
// register is moved through its extremes between phases while the engine is
// idle.
// ============================================================================
`timescale 1ns / 1ps

module bit_vector_range_engine_test;
   import bvre_pkg::*;

   localparam int WORDS        = 8;
   // Longest item visits every word, plus the fixed overhead and some slack.
   localparam int DRAIN_CYCLES = WORDS + 3 + 6;
   localparam int PHASE_ITEMS  = 62;

   // One operation beat as the sender sees it.
   typedef struct packed {
      kind_type            kind;
      logic [POS_BITS-1:0] first_bit;
      logic [POS_BITS-1:0] last_bit;
   } bitmap_op_type;

   // One result beat.
   typedef struct packed {
      logic                hit;
      logic [POS_BITS-1:0] position;
      logic                error;
   } bitmap_result_type;

   logic                clock;
   logic                reset;
   logic                csr_write_en;
   logic [BIU_BITS-1:0] csr_write_data;

   bvre_req_if req_bus ();
   bvre_rsp_if rsp_bus ();

   bit_vector_range_engine #(
      .WORDS(WORDS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   // Shadow state of the engine.
   logic [WORD_BITS-1:0] bitmap_image [WORDS];
   logic [BIU_BITS-1:0]  vector_length;

   bitmap_op_type     pending_ops [$];
   bitmap_result_type expected_results [$];
   int                fail_count;

   // Driver and monitor bookkeeping.
   bit                req_beat_taken;
   int                burst_left;
   int                gap_left;
   bitmap_op_type     next_op;
   bitmap_op_type     accepted_op;
   bitmap_result_type wanted;
   bitmap_result_type seen;
   int                ready_mode;
   int                ready_span;
   logic [15:0]       ready_pattern;

   // Applies one operation to the shadow bitmap and returns its result.
   function automatic bitmap_result_type apply_bitmap_op(bitmap_op_type op);
      bitmap_result_type    res;
      int                   lo;
      int                   hi;
      int                   covered;
      int                   w;
      int                   b;
      logic [WORD_BITS-1:0] mask;
      res = '0;
      lo  = op.first_bit;
      hi  = op.last_bit;
      covered = (int'(vector_length) + 31) >> 5;
      if (covered > WORDS) covered = WORDS;
      case (op.kind)
         KIND_SET_BIT, KIND_CLEAR_BIT: begin
            if ((lo >> 5) < WORDS)
               bitmap_image[lo >> 5][lo & 31] = (op.kind == KIND_SET_BIT);
         end
         KIND_SET_RANGE, KIND_CLEAR_RANGE, KIND_TEST_RANGE: begin
            if (lo > hi) begin
               res.error = 1'b1;
            end else begin
               for (w = 0; w < WORDS; w++) begin
                  mask = '0;
                  for (b = 0; b < WORD_BITS; b++)
                     if (w * 32 + b >= lo && w * 32 + b <= hi) mask[b] = 1'b1;
                  if (op.kind == KIND_SET_RANGE) bitmap_image[w] |= mask;
                  else if (op.kind == KIND_CLEAR_RANGE) bitmap_image[w] &= ~mask;
                  else if ((bitmap_image[w] & mask) != '0) res.hit = 1'b1;
               end
            end
         end
         KIND_SET_ALL, KIND_CLEAR_ALL: begin
            for (w = 0; w < covered; w++)
               bitmap_image[w] = (op.kind == KIND_SET_ALL) ? '1 : '0;
         end
         default: begin
            // Search from the top covered word down; the first set bit wins.
            for (w = covered - 1; w >= 0; w--)
               if (!res.hit && bitmap_image[w] != '0)
                  for (b = WORD_BITS - 1; b >= 0; b--)
                     if (!res.hit && bitmap_image[w][b]) begin
                        res.hit      = 1'b1;
                        res.position = POS_BITS'(w * 32 + b);
                     end
         end
      endcase
      return res;
   endfunction

   // Bit positions lean toward word boundaries, where masks change shape.
   function automatic logic [POS_BITS-1:0] pick_bit();
      if ($urandom_range(0, 3) == 0)
         return POS_BITS'($urandom_range(0, 7) * 32 + ($urandom_range(0, 1) ? 31 : 0));
      return POS_BITS'($urandom_range(0, 255));
   endfunction

   // Random operation: mostly well-formed ranges, some reversed or unrelated.
   function automatic bitmap_op_type random_op();
      bitmap_op_type op;
      int            pick;
      int            span;
      pick = $urandom_range(0, 99);
      if (pick < 15)      op.kind = KIND_SET_BIT;
      else if (pick < 27) op.kind = KIND_CLEAR_BIT;
      else if (pick < 42) op.kind = KIND_SET_RANGE;
      else if (pick < 54) op.kind = KIND_CLEAR_RANGE;
      else if (pick < 72) op.kind = KIND_TEST_RANGE;
      else if (pick < 76) op.kind = KIND_SET_ALL;
      else if (pick < 81) op.kind = KIND_CLEAR_ALL;
      else                op.kind = KIND_FIND_HIGH;
      op.first_bit = pick_bit();
      op.last_bit  = POS_BITS'($urandom_range(0, 255));
      if (op.kind inside {KIND_SET_RANGE, KIND_CLEAR_RANGE, KIND_TEST_RANGE}) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            op.first_bit = POS_BITS'($urandom_range(1, 255));
            op.last_bit  = POS_BITS'($urandom_range(0, op.first_bit - 1));
         end else if (pick >= 25) begin
            span = (pick < 45) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            op.last_bit = (op.first_bit + span > 255) ? 8'd255 : POS_BITS'(op.first_bit + span);
         end
      end
      return op;
   endfunction

   task automatic queue_op(kind_type kind, int first_bit, int last_bit);
      bitmap_op_type op;
      op.kind      = kind;
      op.first_bit = POS_BITS'(first_bit);
      op.last_bit  = POS_BITS'(last_bit);
      pending_ops.push_back(op);
   endtask

   // Waits until every beat is sent and answered, then lets the engine settle.
   task automatic wait_idle();
      while (pending_ops.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(int value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= BIU_BITS'(value);
      vector_length  = BIU_BITS'(value);
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Clock and reset.
   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.kind       = '0;
      req_bus.start_req  = '0;
      req_bus.end_pos    = '0;
      rsp_bus.ready      = 1'b0;
      fail_count         = 0;
      req_beat_taken     = 1'b0;
      burst_left         = 0;
      gap_left           = 0;
      ready_mode         = 0;
      ready_span         = 0;
      ready_pattern      = 16'h5A5B;
      vector_length      = BIU_RESET;
      foreach (bitmap_image[i]) bitmap_image[i] = '0;
      fork
         forever #1 clock = ~clock;
      join_none
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: sends queued operations in bursts separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_beat_taken) begin
         // Hold the beat until it is taken.
      end else begin
         req_beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid     <= 1'b0;
            req_bus.start_req <= POS_BITS'($urandom);
         end else if (pending_ops.size() != 0) begin
            next_op = pending_ops.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.kind      <= next_op.kind;
            req_bus.start_req <= next_op.first_bit;
            req_bus.end_pos   <= next_op.last_bit;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Receiver: ready follows a mode that is picked anew after a random span.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (ready_span == 0) begin
            ready_span    = $urandom_range(20, 60);
            ready_mode    = $urandom_range(0, 2);
            ready_pattern = 16'($urandom) | 16'h0001;
         end
         ready_span--;
         case (ready_mode)
            0: rsp_bus.ready <= 1'b1;
            1: begin
               rsp_bus.ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            end
            default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Each accepted operation beat updates the shadow bitmap and queues a result.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         accepted_op.kind      = kind_type'(req_bus.kind);
         accepted_op.first_bit = req_bus.start_req;
         accepted_op.last_bit  = req_bus.end_pos;
         expected_results.push_back(apply_bitmap_op(accepted_op));
         req_beat_taken = 1'b1;
      end
   end

   // Monitor: compares each result beat with the oldest expected result.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.hit      = rsp_bus.hit;
         seen.position = rsp_bus.position;
         seen.error    = rsp_bus.error;
         if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: hit %0d position %0d error %0d",
                   seen.hit, seen.position, seen.error);
            fail_count++;
         end else begin
            wanted = expected_results.pop_front();
            if (seen.hit !== wanted.hit) begin
               $error("hit: expected %0d, got %0d", wanted.hit, seen.hit);
               fail_count++;
            end
            if (seen.position !== wanted.position) begin
               $error("position: expected %0d, got %0d", wanted.position, seen.position);
               fail_count++;
            end
            if (seen.error !== wanted.error) begin
               $error("error: expected %0d, got %0d", wanted.error, seen.error);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: directed corner cases, then random phases at several lengths.
   initial begin
      int lengths [9];
      lengths = '{1, 0, 511, 33, 32, 255, 0, 0, 256};
      lengths[6] = $urandom_range(0, 511);
      lengths[7] = $urandom_range(0, 511);
      @(posedge clock);
      while (reset) @(posedge clock);

      // Extremes of the fields, every kind and the reversed ranges.
      queue_op(KIND_FIND_HIGH,   0,   0);
      queue_op(KIND_SET_BIT,     0,   255);
      queue_op(KIND_SET_BIT,     255, 0);
      queue_op(KIND_FIND_HIGH,   0,   0);
      queue_op(KIND_TEST_RANGE,  1,   254);
      queue_op(KIND_TEST_RANGE,  0,   0);
      queue_op(KIND_CLEAR_BIT,   255, 255);
      queue_op(KIND_FIND_HIGH,   0,   0);
      queue_op(KIND_SET_RANGE,   31,  32);
      queue_op(KIND_TEST_RANGE,  32,  32);
      queue_op(KIND_FIND_HIGH,   0,   0);
      queue_op(KIND_SET_RANGE,   0,   255);
      queue_op(KIND_CLEAR_RANGE, 1,   254);
      queue_op(KIND_TEST_RANGE,  1,   254);
      queue_op(KIND_TEST_RANGE,  0,   255);
      queue_op(KIND_SET_RANGE,   200, 100);
      queue_op(KIND_CLEAR_RANGE, 255, 0);
      queue_op(KIND_TEST_RANGE,  1,   0);
      queue_op(KIND_CLEAR_ALL,   0,   0);
      queue_op(KIND_FIND_HIGH,   255, 255);
      queue_op(KIND_SET_ALL,     0,   0);
      queue_op(KIND_FIND_HIGH,   0,   0);
      queue_op(KIND_CLEAR_RANGE, 0,   255);
      queue_op(KIND_TEST_RANGE,  0,   255);
      wait_idle();

      // Random traffic under each vector length.
      foreach (lengths[p]) begin
         write_length(lengths[p]);
         repeat (PHASE_ITEMS) pending_ops.push_back(random_op());
         wait_idle();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #1000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
